>>> src/pld_pkg.sv
// pld_pkg: shared types and constants for the preamble length deframer
// no dependencies; imported by pld_frame_fsm, pld_out_reg and the top level
`default_nettype none

package pld_pkg;

	localparam int ByteW = 8;
	localparam int WordW = 32;

	// frame phase codes
	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;

	localparam logic [1:0] HDR_LAST = 2'd3;

	typedef struct packed {
		logic             valid;
		logic [ByteW-1:0] data;
		logic             first;
		logic             last;
		logic             empty;
	} pld_result_t;

endpackage

`default_nettype wire

>>> src/pld_frame_fsm.sv
// pld_frame_fsm: preamble hunt, length header assembly and payload countdown
// depends on pld_pkg
`default_nettype none

module pld_frame_fsm (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           step,
	input  wire logic [pld_pkg::ByteW-1:0]      byte_in,
	input  wire logic [pld_pkg::WordW-1:0]      preamble,
	output pld_pkg::pld_result_t                result
);
	import pld_pkg::*;

	logic [1:0]       phase_q, phase_d;
	logic [WordW-1:0] hist_q, hist_d;
	logic [1:0]       hdr_cnt_q, hdr_cnt_d;
	logic [WordW-1:0] len_q, len_d;
	logic [WordW-1:0] remain_q, remain_d;
	logic             seen_q, seen_d;
	logic [WordW-1:0] hist_shift;
	logic [WordW-1:0] len_shift;

	assign hist_shift = {hist_q[WordW-ByteW-1:0], byte_in};
	assign len_shift  = {len_q[WordW-ByteW-1:0], byte_in};

	always_comb begin
		phase_d   = phase_q;
		hist_d    = hist_q;
		hdr_cnt_d = hdr_cnt_q;
		len_d     = len_q;
		remain_d  = remain_q;
		seen_d    = seen_q;
		result    = '0;
		case (phase_q)
			PH_LEN: begin
				len_d = len_shift;
				if (hdr_cnt_q == HDR_LAST) begin
					hdr_cnt_d = '0;
					if (len_shift == '0) begin
						// zero length: one empty marker, then hunt again
						result.valid = 1'b1;
						result.first = 1'b1;
						result.last  = 1'b1;
						result.empty = 1'b1;
						phase_d      = PH_HUNT;
						hist_d       = '0;
						len_d        = '0;
						remain_d     = '0;
						seen_d       = 1'b0;
					end else begin
						remain_d = len_shift;
						seen_d   = 1'b0;
						phase_d  = PH_DATA;
					end
				end else begin
					hdr_cnt_d = hdr_cnt_q + 2'd1;
				end
			end
			PH_DATA: begin
				result.valid = 1'b1;
				result.data  = byte_in;
				result.first = ~seen_q;
				result.last  = (remain_q == WordW'(1));
				seen_d       = 1'b1;
				remain_d     = remain_q - WordW'(1);
				if (remain_q == WordW'(1)) begin
					phase_d   = PH_HUNT;
					hist_d    = '0;
					hdr_cnt_d = '0;
					len_d     = '0;
					seen_d    = 1'b0;
				end
			end
			default: begin
				// hunting; the unused phase code behaves the same
				phase_d = PH_HUNT;
				hist_d  = hist_shift;
				if (hist_shift == preamble) begin
					phase_d   = PH_LEN;
					hdr_cnt_d = '0;
					len_d     = '0;
				end
			end
		endcase
		if (!step) begin
			result.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			hist_q    <= '0;
			hdr_cnt_q <= '0;
			len_q     <= '0;
			remain_q  <= '0;
			seen_q    <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			hist_q    <= hist_d;
			hdr_cnt_q <= hdr_cnt_d;
			len_q     <= len_d;
			remain_q  <= remain_d;
			seen_q    <= seen_d;
		end
	end

endmodule

`default_nettype wire

>>> src/pld_out_reg.sv
// pld_out_reg: result register holding one request for the output channel
// depends on pld_pkg
`default_nettype none

module pld_out_reg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       load,
	input  wire pld_pkg::pld_result_t       result,
	input  wire logic                       out_ready,
	output logic                            out_valid,
	output logic                            free,
	output logic [pld_pkg::ByteW-1:0]       payload_byte,
	output logic                            first_of_frame,
	output logic                            last_of_frame,
	output logic                            empty_frame
);
	import pld_pkg::*;

	logic             valid_q;
	logic [ByteW-1:0] data_q;
	logic             first_q;
	logic             last_q;
	logic             empty_q;

	// room for a new result when empty or being taken this cycle
	assign free = ~valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= result.valid;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && result.valid) begin
			data_q  <= result.data;
			first_q <= result.first;
			last_q  <= result.last;
			empty_q <= result.empty;
		end
	end

	assign out_valid      = valid_q;
	assign payload_byte   = data_q;
	assign first_of_frame = first_q;
	assign last_of_frame  = last_q;
	assign empty_frame    = empty_q;

endmodule

`default_nettype wire

>>> src/preamble_length_deframer_unit.sv
// preamble_length_deframer_unit: top level with input register and config register
// depends on pld_pkg, pld_frame_fsm, pld_out_reg
//
//   channel   signals                                            dir
//   cfg       cfg_valid cfg_ready preamble_word                  in
//   rx        rx_valid rx_ready rx_byte                          in
//   out       out_valid out_ready payload_byte first_of_frame
//             last_of_frame empty_frame                          out
//
// one byte per cycle sustained while out is not stalled; a byte is registered, then
// decoded against the frame state and its result (if any) is loaded into the output
// register once that register is free
// reset clears frame state, the preamble register and both valid flags
// an out stall holds the input register; rx_ready drops only while both are full
`default_nettype none

module preamble_length_deframer_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [pld_pkg::WordW-1:0]   preamble_word,
	input  wire logic                        rx_valid,
	output logic                             rx_ready,
	input  wire logic [pld_pkg::ByteW-1:0]   rx_byte,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [pld_pkg::ByteW-1:0]        payload_byte,
	output logic                             first_of_frame,
	output logic                             last_of_frame,
	output logic                             empty_frame
);
	import pld_pkg::*;

	logic [WordW-1:0] preamble_q;
	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             out_free;
	logic             step;
	pld_result_t      result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_q <= '0;
		end else if (cfg_valid) begin
			preamble_q <= preamble_word;
		end
	end

	assign step     = valid_s1 & out_free;
	assign rx_ready = ~valid_s1 | out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	pld_frame_fsm u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.byte_in  (byte_s1),
		.preamble (preamble_q),
		.result   (result)
	);

	pld_out_reg u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (step),
		.result         (result),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.free           (out_free),
		.payload_byte   (payload_byte),
		.first_of_frame (first_of_frame),
		.last_of_frame  (last_of_frame),
		.empty_frame    (empty_frame)
	);

endmodule

`default_nettype wire

>>> verif/pld_frame_checker.sv
// pld_frame_checker: watches the config, rx and out channels of the deframer, predicts
// each result from the accepted bytes and compares it field by field
// depends on pld_pkg; instantiated beside the block by preamble_length_deframer_unit_test

module pld_frame_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [pld_pkg::WordW-1:0]   preamble_word,
	input  logic                        rx_valid,
	input  logic                        rx_ready,
	input  logic [pld_pkg::ByteW-1:0]   rx_byte,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [pld_pkg::ByteW-1:0]   payload_byte,
	input  logic                        first_of_frame,
	input  logic                        last_of_frame,
	input  logic                        empty_frame,
	output int unsigned                 mismatches,
	output int unsigned                 waiting,
	output int unsigned                 results_checked,
	output int unsigned                 frames_closed,
	output int unsigned                 empty_markers
);
	timeunit 1ns;
	timeprecision 1ps;

	import pld_pkg::*;

	logic [WordW-1:0] preamble_copy = '0;
	logic [WordW-1:0] history = '0;
	logic [WordW-1:0] length_sum = '0;
	logic [WordW-1:0] remaining = '0;
	logic [1:0]       phase = PH_HUNT;
	logic [1:0]       hdr_count = '0;
	logic             first_sent = 1'b0;

	pld_result_t pending_out[$];
	int unsigned bad_fields = 0;
	int unsigned checked = 0;
	int unsigned closed = 0;
	int unsigned empties = 0;

	task automatic restart_hunt();
		phase = PH_HUNT;
		history = '0;
		hdr_count = '0;
		length_sum = '0;
		remaining = '0;
		first_sent = 1'b0;
	endtask

	task automatic decode_byte(input logic [ByteW-1:0] b);
		pld_result_t r;
		r = '0;
		r.valid = 1'b1;
		case (phase)
			PH_LEN: begin
				length_sum = {length_sum[WordW-ByteW-1:0], b};
				if (hdr_count == HDR_LAST) begin
					hdr_count = '0;
					if (length_sum == '0) begin
						r.first = 1'b1;
						r.last = 1'b1;
						r.empty = 1'b1;
						pending_out.push_back(r);
						empties++;
						restart_hunt();
					end else begin
						remaining = length_sum;
						first_sent = 1'b0;
						phase = PH_DATA;
					end
				end else begin
					hdr_count = hdr_count + 2'd1;
				end
			end
			PH_DATA: begin
				r.data = b;
				r.first = !first_sent;
				r.last = (remaining == 1);
				pending_out.push_back(r);
				first_sent = 1'b1;
				remaining = remaining - 1;
				if (remaining == '0) begin
					closed++;
					restart_hunt();
				end
			end
			default: begin
				// the spare phase code behaves like hunting
				phase = PH_HUNT;
				history = {history[WordW-ByteW-1:0], b};
				if (history == preamble_copy) begin
					phase = PH_LEN;
					hdr_count = '0;
					length_sum = '0;
				end
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [ByteW-1:0] want,
		input logic [ByteW-1:0] got);
		if (got !== want) begin
			bad_fields++;
			$error("%s expected %0h actual %0h", name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pld_result_t want;
		if (!arst_n) begin
			preamble_copy = '0;
			restart_hunt();
			pending_out.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (pending_out.size() == 0) begin
					bad_fields++;
					$error("result with nothing expected: payload_byte %0h", payload_byte);
				end else begin
					want = pending_out.pop_front();
					checked++;
					check_field("payload_byte", want.data, payload_byte);
					check_field("first_of_frame", ByteW'(want.first), ByteW'(first_of_frame));
					check_field("last_of_frame", ByteW'(want.last), ByteW'(last_of_frame));
					check_field("empty_frame", ByteW'(want.empty), ByteW'(empty_frame));
				end
			end
			if (cfg_valid && cfg_ready)
				preamble_copy = preamble_word;
			if (rx_valid && rx_ready)
				decode_byte(rx_byte);
		end
		mismatches <= bad_fields;
		waiting <= pending_out.size();
		results_checked <= checked;
		frames_closed <= closed;
		empty_markers <= empties;
	end

endmodule

>>> verif/preamble_length_deframer_unit_test.sv
// preamble_length_deframer_unit_test: stimulus, idling and verdict for the deframer
// depends on pld_pkg, preamble_length_deframer_unit and pld_frame_checker

module preamble_length_deframer_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pld_pkg::*;

	localparam int unsigned StuckLimit = 600;
	localparam int unsigned DrainCycles = 4;
	localparam int unsigned EndCycles = 8;
	localparam int unsigned RandPhases = 8;
	localparam int unsigned BytesPerPhase = 236;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [WordW-1:0] preamble_word = '0;
	logic rx_valid = 1'b0;
	logic rx_ready;
	logic [ByteW-1:0] rx_byte = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ByteW-1:0] payload_byte;
	logic first_of_frame;
	logic last_of_frame;
	logic empty_frame;

	int unsigned mismatches;
	int unsigned waiting;
	int unsigned results_checked;
	int unsigned frames_closed;
	int unsigned empty_markers;

	logic calm = 1'b0;
	logic no_idle = 1'b0;
	int unsigned rx_sent = 0;
	int unsigned settings_used = 0;
	int unsigned stuck_cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	preamble_length_deframer_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.preamble_word  (preamble_word),
		.rx_valid       (rx_valid),
		.rx_ready       (rx_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.payload_byte   (payload_byte),
		.first_of_frame (first_of_frame),
		.last_of_frame  (last_of_frame),
		.empty_frame    (empty_frame)
	);

	pld_frame_checker frame_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.preamble_word   (preamble_word),
		.rx_valid        (rx_valid),
		.rx_ready        (rx_ready),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.payload_byte    (payload_byte),
		.first_of_frame  (first_of_frame),
		.last_of_frame   (last_of_frame),
		.empty_frame     (empty_frame),
		.mismatches      (mismatches),
		.waiting         (waiting),
		.results_checked (results_checked),
		.frames_closed   (frames_closed),
		.empty_markers   (empty_markers)
	);

	// any accepted request restarts the count
	always @(posedge clk) begin
		if (!arst_n || (rx_valid && rx_ready) || (out_valid && out_ready)
			|| (cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
		if (stuck_cycles == StuckLimit) begin
			$display("no request accepted for %0d cycles", StuckLimit);
			$display("FAIL preamble_length_deframer_unit");
			$finish;
		end
	end

	// stretches without idling on either side
	initial begin
		forever begin
			repeat ($urandom_range(150, 400)) @(posedge clk);
			calm <= 1'b1;
			repeat ($urandom_range(40, 120)) @(posedge clk);
			calm <= 1'b0;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (!calm && !no_idle && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic send_byte(input logic [ByteW-1:0] b);
		if (!calm && !no_idle && $urandom_range(0, 4) == 0) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!rx_ready) @(posedge clk);
		rx_sent++;
	endtask

	// big-endian, as preamble and length go on the link
	task automatic send_word(input logic [WordW-1:0] w);
		for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
	endtask

	// noise never holds a preamble byte, so it cannot form a false match
	task automatic send_noise(input logic [WordW-1:0] pw, input int unsigned n);
		logic [ByteW-1:0] b;
		repeat (n) begin
			b = ByteW'($urandom);
			while (b == pw[31:24] || b == pw[23:16] || b == pw[15:8] || b == pw[7:0])
				b = ByteW'($urandom);
			send_byte(b);
		end
	endtask

	task automatic send_frame(input logic [WordW-1:0] pw, input logic [WordW-1:0] len);
		send_word(pw);
		send_word(len);
		for (int unsigned i = 0; i < len; i++) send_byte(ByteW'($urandom));
	endtask

	task automatic wait_drained(input int unsigned extra);
		rx_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_preamble(input logic [WordW-1:0] w);
		cfg_valid <= 1'b1;
		preamble_word <= w;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// distinct bytes keep the preamble from overlapping itself
	function automatic logic [WordW-1:0] pick_preamble();
		logic [WordW-1:0] w;
		do
			w = $urandom;
		while (w[31:24] == w[23:16] || w[31:24] == w[15:8] || w[31:24] == w[7:0]
			|| w[23:16] == w[15:8] || w[23:16] == w[7:0] || w[15:8] == w[7:0]);
		return w;
	endfunction

	initial begin
		logic [WordW-1:0] pw;
		logic [WordW-1:0] len;
		int unsigned mark;
		int unsigned pick;
		int unsigned cut;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_preamble('0);
		// zero preamble matches on a zero byte while history is clear
		send_byte(8'h00);
		send_word('0);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		// new preamble lands mid-header and only counts at the next hunt
		wait_drained(DrainCycles);
		write_preamble('1);
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'h00);
		send_word('1);
		send_word(32'd2);
		send_byte(8'hFF);
		send_byte(8'h80);
		wait_drained(DrainCycles);
		write_preamble(32'h1212_1234);
		// repeated leading byte, the match lands on the fifth byte
		send_word(32'h1212_1212);
		send_byte(8'h34);
		send_word('0);

		for (int p = 0; p < RandPhases; p++) begin
			pw = pick_preamble();
			wait_drained(DrainCycles);
			write_preamble(pw);
			no_idle <= (p == RandPhases - 1);
			mark = rx_sent;
			while (rx_sent - mark < BytesPerPhase) begin
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					// broken preamble: a proper prefix, then noise
					cut = $urandom_range(1, 3);
					for (int i = 3; i > 3 - int'(cut); i--) send_byte(pw[8*i +: 8]);
					send_noise(pw, $urandom_range(1, 3));
				end else if (pick == 1) begin
					send_noise(pw, $urandom_range(1, 6));
				end else begin
					send_noise(pw, $urandom_range(0, 2));
					if ($urandom_range(0, 7) == 0)
						len = $urandom_range(13, 64);
					else
						len = $urandom_range(0, 12);
					send_frame(pw, len);
				end
			end
		end

		// largest length: only the start of that frame is sent
		send_word(pw);
		send_word('1);
		repeat (5) send_byte(ByteW'($urandom));

		wait_drained(EndCycles);
		$display("covered %0d rx bytes under %0d preamble settings, overlap and mid-header",
			rx_sent, settings_used);
		$display("checked %0d results: %0d frames closed, %0d empty markers",
			results_checked, frames_closed, empty_markers);
		if (waiting != 0)
			$error("%0d expected results never arrived", waiting);
		if (mismatches == 0 && waiting == 0) begin
			$display("PASS preamble_length_deframer_unit");
		end else begin
			$display("FAIL preamble_length_deframer_unit");
		end
		$finish;
	end

endmodule
